// File: src/sss_pkg.sv
// ----------------------------------------------------------------------------
// Stream string substitute package
// Shared types and constants: payload structs, configuration view, the
// command that travels from the match front end to the output sequencer.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int PAT_MAX    = 16;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CMD_DEPTH  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO  = 3'd0,
        CFG_PAT_HI  = 3'd1,
        CFG_PAT_LEN = 3'd2,
        CFG_REP_LO  = 3'd3,
        CFG_REP_HI  = 3'd4,
        CFG_REP_LEN = 3'd5
    } t_cfg_idx;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_stream_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_from_replacement;
        logic       out_run_last;
        logic       out_stream_end;
    } t_out_item;

    typedef struct packed {
        t_byte [PAT_MAX-1:0] pat;
        logic [LEN_W-1:0]    plen;
        logic                plen_wr;
        t_byte [PAT_MAX-1:0] rep;
        logic [LEN_W-1:0]    rlen;
    } t_cfg;

    typedef struct packed {
        logic                lead_repl;
        t_byte               pass_byte;
        logic [LEN_W-1:0]    lead_cnt;
        logic [LEN_W-1:0]    flush_cnt;
        t_byte [PAT_MAX-1:0] flush;
        logic                stream_end;
    } t_cmd;

endpackage

// File: src/sss_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds pattern and replacement registers and presents their clamped lengths.
// ----------------------------------------------------------------------------
module sss_cfg #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sss_pkg::t_cfg                  o_cfg
);
    import sss_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    logic [CFG_DATA_W-1:0] r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [LEN_W-1:0]      r_plen, r_rlen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_plen   <= LEN_W'(1);
            r_rep_lo <= '0;
            r_rep_hi <= '0;
            r_rlen   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PAT_LO:  r_pat_lo <= i_cfg_data;
                CFG_PAT_HI:  r_pat_hi <= i_cfg_data;
                CFG_PAT_LEN: r_plen   <= i_cfg_data[LEN_W-1:0];
                CFG_REP_LO:  r_rep_lo <= i_cfg_data;
                CFG_REP_HI:  r_rep_hi <= i_cfg_data;
                CFG_REP_LEN: r_rlen   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.pat = {r_pat_hi, r_pat_lo};
        o_cfg.rep = {r_rep_hi, r_rep_lo};
        if (r_plen == '0) begin
            o_cfg.plen = LEN_W'(1);
        end else if (r_plen > MAX_LEN) begin
            o_cfg.plen = MAX_LEN;
        end else begin
            o_cfg.plen = r_plen;
        end
        o_cfg.rlen    = (r_rlen > MAX_LEN) ? MAX_LEN : r_rlen;
        o_cfg.plen_wr = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_PAT_LEN);
    end

endmodule

// File: src/sss_front.sv
// ----------------------------------------------------------------------------
// Match front end
// Keeps the match window, compares it with the pattern and turns each
// accepted byte that causes output into one output command.
// ----------------------------------------------------------------------------
module sss_front #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sss_pkg::t_cfg     i_cfg,
    input  logic              i_accept,
    input  sss_pkg::t_in_item i_item,
    output sss_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid
);
    import sss_pkg::*;

    t_byte            r_win [MAX_PATTERN_BYTES];
    t_byte            n_win [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0] r_fill, n_fill;

    t_byte            w_app [MAX_PATTERN_BYTES];
    t_byte            w_sh  [MAX_PATTERN_BYTES];
    logic [LEN_W-1:0] fill_app, rem_cnt;
    logic             win_full, hit;

    always_comb begin
        fill_app = r_fill + LEN_W'(1);
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            w_app[i] = (r_fill == LEN_W'(i)) ? i_item.in_byte : r_win[i];
        end
        for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
            w_sh[i] = w_app[i+1];
        end
        w_sh[MAX_PATTERN_BYTES-1] = w_app[MAX_PATTERN_BYTES-1];

        win_full = (fill_app == i_cfg.plen);
        hit      = win_full;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            if ((LEN_W'(i) < i_cfg.plen) && (w_app[i] != i_cfg.pat[i])) begin
                hit = 1'b0;
            end
        end

        o_cmd.lead_repl  = 1'b0;
        o_cmd.pass_byte  = w_app[0];
        o_cmd.lead_cnt   = '0;
        o_cmd.stream_end = i_item.in_stream_end;
        n_win            = w_app;
        rem_cnt          = fill_app;
        if (win_full && hit) begin
            o_cmd.lead_repl = 1'b1;
            o_cmd.lead_cnt  = i_cfg.rlen;
            rem_cnt         = '0;
        end else if (win_full) begin
            o_cmd.lead_cnt = LEN_W'(1);
            n_win          = w_sh;
            rem_cnt        = fill_app - LEN_W'(1);
        end

        o_cmd.flush = '0;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            o_cmd.flush[i] = n_win[i];
        end
        if (i_item.in_stream_end) begin
            o_cmd.flush_cnt = rem_cnt;
            n_fill          = '0;
        end else begin
            o_cmd.flush_cnt = '0;
            n_fill          = rem_cnt;
        end

        o_cmd_valid = i_accept && ((o_cmd.lead_cnt != '0) || (o_cmd.flush_cnt != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cfg.plen_wr) begin
            r_fill <= '0;
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

`ifndef SYNTHESIS
    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < i_cfg.plen)
        else $error("match window holds a full pattern between requests");
`endif

endmodule

// File: src/sss_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short register queue that decouples the match front end from the output
// sequencer.
// ----------------------------------------------------------------------------
module sss_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  sss_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output sss_pkg::t_cmd o_cmd,
    input  logic          i_rd
);
    import sss_pkg::*;

    localparam int PW = $clog2(CMD_DEPTH);

    t_cmd          r_mem [CMD_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr |-> !o_full) and (i_rd |-> o_valid))
        else $error("command queue written while full or read while empty");
`endif

endmodule

// File: src/sss_back.sv
// ----------------------------------------------------------------------------
// Output sequencer
// Expands each command into its result bytes, writing them into the output
// register one per cycle while it is empty or being popped.
// ----------------------------------------------------------------------------
module sss_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sss_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  sss_pkg::t_cmd      i_cmd,
    output logic               o_cmd_rd,
    output logic               o_empty,
    input  logic               i_pop,
    output sss_pkg::t_out_item o_result
);
    import sss_pkg::*;

    localparam int BI_W = $clog2(PAT_MAX);

    logic [LEN_W-1:0] r_pos, n_pos;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [LEN_W:0]   total;
    logic [LEN_W-1:0] fidx;
    logic             last, fire;

    always_comb begin
        total = {1'b0, i_cmd.lead_cnt} + {1'b0, i_cmd.flush_cnt};
        last  = ({1'b0, r_pos} == (total - (LEN_W+1)'(1)));
        fidx  = r_pos - i_cmd.lead_cnt;
        fire  = i_cmd_valid && (!r_out_valid || i_pop);

        n_out.out_run_last   = last;
        n_out.out_stream_end = last && i_cmd.stream_end;
        if (r_pos < i_cmd.lead_cnt) begin
            n_out.out_from_replacement = i_cmd.lead_repl;
            n_out.out_byte = i_cmd.lead_repl ? i_cfg.rep[r_pos[BI_W-1:0]] : i_cmd.pass_byte;
        end else begin
            n_out.out_from_replacement = 1'b0;
            n_out.out_byte             = i_cmd.flush[fidx[BI_W-1:0]];
        end

        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_pop;
        if (fire) begin
            n_pos       = last ? '0 : r_pos + LEN_W'(1);
            n_out_valid = 1'b1;
        end
    end

    assign o_cmd_rd = fire && last;
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> ({1'b0, r_pos} < total))
        else $error("sequencer position runs past the current command");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.out_stream_end) |-> r_out.out_run_last)
        else $error("stream end shown on a result that does not close its run");
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_rd |=> (r_pos == '0))
        else $error("sequencer does not restart after finishing a command");
`endif

endmodule

// File: src/stream_string_substitute_top.sv
// ----------------------------------------------------------------------------
// Stream string substitute
// Replaces non-overlapping occurrences of a configured byte pattern in a
// byte stream with a configured replacement, flushing held bytes at stream
// end.
//
// Channel    Direction  Handshake         Payload
// input      in         push / full       i_item   (t_in_item)
// result     out        pop / empty       o_result (t_out_item)
// config     in         i_cfg_we          i_cfg_idx, i_cfg_data
//
// A byte that causes at most one result is taken every cycle while the command queue is not full.
// A request causes one result for a passed byte, R for a match with an R-byte
// replacement, plus one per held byte flushed at stream end; the sequencer
// writes them one at a time and a four-entry command queue absorbs the difference.
// The first result of a request passes through the command queue and the output
// register before it reaches the result ports.
// Reset is synchronous; the window needs no clearing.
// ----------------------------------------------------------------------------
module stream_string_substitute_top #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  sss_pkg::t_in_item              i_item,
    output logic                           empty,
    input  logic                           pop,
    output sss_pkg::t_out_item             o_result
);
    import sss_pkg::*;

    t_cfg cfg;
    t_cmd front_cmd, fifo_cmd;
    logic accept, front_valid, fifo_valid, fifo_rd;

    assign accept = push && !full;

    sss_cfg #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sss_front #(
        .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_item      (i_item),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid)
    );

    sss_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_valid (fifo_valid),
        .o_cmd   (fifo_cmd),
        .i_rd    (fifo_rd)
    );

    sss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (fifo_valid),
        .i_cmd       (fifo_cmd),
        .o_cmd_rd    (fifo_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Stream string substitute testbench
// Drives byte streams through the queue-style input port and checks every
// output byte against an in-bench substitution predictor or a result given in
// the directed table. A short table of directed requests and register writes
// covers the length extremes, deletion, stream-end flushing and ignored
// register indexes. Random phases follow, each rewriting a random choice of
// settings, with streams built mostly from pattern copies.
module testbench;

    import sss_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 230;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT = 400000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 3'd7;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_ONE,
        ROW_NONE
    } t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        t_in_item               req;
        t_out_item              res;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    t_in_item              i_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_out_item             o_result;

    logic [63:0]   pat_lo, pat_hi, rep_lo, rep_hi;
    logic [4:0]    pat_len_reg, rep_len_reg;
    t_byte         win [PAT_MAX];
    int unsigned   win_fill;

    t_out_item     predicted_bytes [$];
    int unsigned   mismatches = 0;
    int unsigned   cycle_count = 0;
    int unsigned   burst_left = 0;
    int unsigned   stall_step = 0;
    logic [15:0]   stall_mask = '0;

    t_dir_row directed_rows [31] = '{
        '{ROW_NONE,    CFG_PAT_LO,  64'd0, t_in_item'{8'h00, 1'b0}, '0},
        '{ROW_ONE,     CFG_PAT_LO,  64'd0, t_in_item'{8'hFF, 1'b0},
          t_out_item'{8'hFF, 1'b0, 1'b1, 1'b0}},
        '{ROW_NONE,    CFG_PAT_LO,  64'd0, t_in_item'{8'h00, 1'b1}, '0},
        '{ROW_ONE,     CFG_PAT_LO,  64'd0, t_in_item'{8'h80, 1'b1},
          t_out_item'{8'h80, 1'b0, 1'b1, 1'b1}},
        '{ROW_CFG,     CFG_PAT_LEN, 64'd0, '0, '0},
        '{ROW_CFG,     CFG_PAT_LO,  64'h0000_0000_0000_00A5, '0, '0},
        '{ROW_CFG,     CFG_REP_LEN, 64'h0000_0000_0000_001F, '0, '0},
        '{ROW_CFG,     CFG_REP_LO,  64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
        '{ROW_CFG,     CFG_REP_HI,  64'h0123_4567_89AB_CDEF, '0, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'hA5, 1'b0}, '0},
        '{ROW_ONE,     CFG_PAT_LO,  64'd0, t_in_item'{8'h5A, 1'b1},
          t_out_item'{8'h5A, 1'b0, 1'b1, 1'b1}},
        '{ROW_CFG,     CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
        '{ROW_CFG,     CFG_PAT_HI,  64'hFFFF_FFFF_FFFF_FFFF, '0, '0},
        '{ROW_CFG,     CFG_REP_LEN, 64'd0, '0, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h01, 1'b0}, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h02, 1'b0}, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h03, 1'b1}, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h04, 1'b0}, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h05, 1'b0}, '0},
        '{ROW_CFG,     CFG_PAT_LEN, 64'd2, '0, '0},
        '{ROW_CFG,     CFG_PAT_LO,  64'h0000_0000_0000_0807, '0, '0},
        '{ROW_CFG,     CFG_REP_LEN, 64'd3, '0, '0},
        '{ROW_CFG,     CFG_REP_LO,  64'h0000_0000_00C3_B2A1, '0, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h07, 1'b0}, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h08, 1'b0}, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h07, 1'b0}, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h09, 1'b1}, '0},
        '{ROW_CFG,     CFG_IDX_UNUSED_LO, 64'h5555_5555_5555_5555, '0, '0},
        '{ROW_CFG,     CFG_IDX_UNUSED_HI, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h07, 1'b0}, '0},
        '{ROW_PREDICT, CFG_PAT_LO,  64'd0, t_in_item'{8'h08, 1'b1}, '0}
    };

    stream_string_substitute_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned pattern_span();
        if (pat_len_reg == 5'd0) begin
            return 1;
        end
        return (pat_len_reg > PAT_MAX) ? PAT_MAX : pat_len_reg;
    endfunction

    function automatic void window_shift(input int unsigned count);
        if (count >= win_fill) begin
            win_fill = 0;
        end else begin
            for (int i = 0; i + count < win_fill; i++) begin
                win[i] = win[i + count];
            end
            win_fill -= count;
        end
    endfunction

    function automatic void substitute_step(input t_in_item req);
        logic [127:0] pat_bits;
        logic [127:0] rep_bits;
        int unsigned  span;
        int unsigned  rep_span;
        int unsigned  first;
        bit           hit;
        pat_bits = {pat_hi, pat_lo};
        rep_bits = {rep_hi, rep_lo};
        span = pattern_span();
        rep_span = (rep_len_reg > PAT_MAX) ? PAT_MAX : rep_len_reg;
        first = predicted_bytes.size();
        if (win_fill < PAT_MAX) begin
            win[win_fill] = req.in_byte;
            win_fill++;
        end
        if (win_fill >= span) begin
            hit = 1'b1;
            for (int i = 0; i < span; i++) begin
                if (win[i] != pat_bits[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
                for (int i = 0; i < rep_span; i++) begin
                    predicted_bytes.push_back(t_out_item'{rep_bits[8*i +: 8], 1'b1, 1'b0, 1'b0});
                end
                window_shift(span);
            end else begin
                predicted_bytes.push_back(t_out_item'{win[0], 1'b0, 1'b0, 1'b0});
                window_shift(1);
            end
        end
        if (req.in_stream_end) begin
            for (int i = 0; i < win_fill && predicted_bytes.size() - first < PAT_MAX; i++) begin
                predicted_bytes.push_back(t_out_item'{win[i], 1'b0, 1'b0, 1'b0});
            end
            win_fill = 0;
        end
        if (predicted_bytes.size() > first) begin
            predicted_bytes[predicted_bytes.size() - 1].out_run_last = 1'b1;
            predicted_bytes[predicted_bytes.size() - 1].out_stream_end = req.in_stream_end;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_PAT_LO: pat_lo = data;
            CFG_PAT_HI: pat_hi = data;
            CFG_PAT_LEN: begin
                pat_len_reg = data[4:0];
                win_fill = 0;
            end
            CFG_REP_LO: rep_lo = data;
            CFG_REP_HI: rep_hi = data;
            CFG_REP_LEN: rep_len_reg = data[4:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_request(input t_in_item req, input t_row_kind kind,
                                input t_out_item typed);
        int unsigned held;
        int unsigned gap;
        @(negedge i_clk);
        push <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        held = predicted_bytes.size();
        substitute_step(req);
        if (kind != ROW_PREDICT) begin
            while (predicted_bytes.size() > held) void'(predicted_bytes.pop_back());
            if (kind == ROW_ONE) predicted_bytes.push_back(typed);
        end
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            if (gap > 0) begin
                @(negedge i_clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain_stream();
        @(negedge i_clk);
        push <= 1'b0;
        while (predicted_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_step % 128 == 0) begin
            case ($urandom_range(0, 2))
                0: stall_mask <= '0;
                1: stall_mask <= 16'($urandom);
                default: stall_mask <= 16'($urandom) | 16'hFF00;
            endcase
        end
        pop <= !stall_mask[stall_step % 16];
        stall_step++;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (predicted_bytes.size() == 0) begin
                $display("%0t: unexpected output byte, expected none, actual %0h",
                         $time, o_result);
                mismatches++;
            end else begin
                want = predicted_bytes.pop_front();
                check_field("out_byte", want.out_byte, o_result.out_byte);
                check_field("out_from_replacement", want.out_from_replacement,
                            o_result.out_from_replacement);
                check_field("out_run_last", want.out_run_last, o_result.out_run_last);
                check_field("out_stream_end", want.out_stream_end, o_result.out_stream_end);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] data;
        logic [127:0]          pat_bits;
        t_byte                 feed_q [$];
        t_in_item              req;
        int unsigned           random_sent;
        int unsigned           phase_len;
        int unsigned           span;
        int unsigned           cut;
        int unsigned           choice;
        bit                    busy;
        pat_lo = '0;
        pat_hi = '0;
        rep_lo = '0;
        rep_hi = '0;
        pat_len_reg = 5'd1;
        rep_len_reg = 5'd0;
        win_fill = 0;
        for (int i = 0; i < PAT_MAX; i++) win[i] = '0;
        random_sent = 0;
        busy = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                if (busy) drain_stream();
                busy = 1'b0;
                write_reg(directed_rows[r].idx, directed_rows[r].data);
            end else begin
                send_request(directed_rows[r].req, directed_rows[r].kind, directed_rows[r].res);
                busy = 1'b1;
            end
        end

        while (random_sent < RANDOM_ITEMS) begin
            drain_stream();
            if ($urandom_range(0, 9) < 6) begin
                data = {$urandom, $urandom};
                choice = $urandom_range(0, 99);
                if (choice < 50) data[4:0] = 5'($urandom_range(1, 3));
                else if (choice < 80) data[4:0] = 5'($urandom_range(4, 8));
                else if (choice < 92) data[4:0] = 5'd16;
                else data[4:0] = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom_range(17, 31));
                write_reg(CFG_PAT_LEN, data);
            end
            if ($urandom_range(0, 3) != 0) write_reg(CFG_PAT_LO, {$urandom, $urandom});
            if ($urandom_range(0, 3) != 0) write_reg(CFG_PAT_HI, {$urandom, $urandom});
            if ($urandom_range(0, 3) != 0) write_reg(CFG_REP_LO, {$urandom, $urandom});
            if ($urandom_range(0, 3) != 0) write_reg(CFG_REP_HI, {$urandom, $urandom});
            if ($urandom_range(0, 3) != 0) begin
                data = {$urandom, $urandom};
                data[4:0] = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                        : 5'($urandom_range(0, 16));
                write_reg(CFG_REP_LEN, data);
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg(($urandom_range(0, 1) != 0) ? CFG_IDX_UNUSED_HI : CFG_IDX_UNUSED_LO,
                          {$urandom, $urandom});
            end
            feed_q.delete();
            phase_len = $urandom_range(10, 40);
            repeat (phase_len) begin
                if (feed_q.size() == 0) begin
                    span = pattern_span();
                    pat_bits = {pat_hi, pat_lo};
                    choice = $urandom_range(0, 9);
                    if (choice < 5) begin
                        for (int i = 0; i < span; i++) feed_q.push_back(pat_bits[8*i +: 8]);
                    end else if (choice < 7) begin
                        cut = $urandom_range(1, span);
                        for (int i = 0; i + 1 < cut; i++) feed_q.push_back(pat_bits[8*i +: 8]);
                        feed_q.push_back(t_byte'($urandom));
                    end else if ($urandom_range(0, 1) != 0) begin
                        feed_q.push_back(t_byte'($urandom));
                    end else begin
                        feed_q.push_back(pat_bits[8*$urandom_range(0, span - 1) +: 8]);
                    end
                end
                req.in_byte = feed_q.pop_front();
                req.in_stream_end = ($urandom_range(0, 23) == 0);
                send_request(req, ROW_PREDICT, '0);
                random_sent++;
            end
        end

        drain_stream();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
